/* src/lfmc_pkg.sv */
// Package for the line-follow motor controller.
// Shared types, register indexes and constants; no dependencies.
package lfmc_pkg;

  // Default number of line sensors
  localparam int unsigned SENSOR_COUNT_DEF = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_FOLLOW_ENABLE = 3'd0,
    REG_TARGET_POSITION    = 3'd1,
    REG_GAIN_NUM           = 3'd2,
    REG_GAIN_SHIFT         = 3'd3,
    REG_POWER_CUTOFF       = 3'd4
  } cfg_reg_e;

  // Reset values of the registers
  localparam logic [6:0] TARGET_RST = 7'd45;
  localparam logic [7:0] GAIN_RST   = 8'd7;
  localparam logic [2:0] SHIFT_RST  = 3'd5;
  localparam logic [6:0] CUTOFF_RST = 7'd80;

  // Position constants
  localparam int unsigned POS_STEP   = 10;
  localparam int unsigned POS_CENTER = 45;
  localparam int unsigned POS_RIGHT  = 90;
  localparam int unsigned POS_LEFT   = 0;

  // Quotient bit index; the 3-bit index covers a quotient of up to 8 bits
  localparam int unsigned DIV_IDX_W = 3;

  typedef enum logic [1:0] {
    DIR_STRAIGHT = 2'd0,
    DIR_RIGHT    = 2'd1,
    DIR_LEFT     = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_DIFF,
    ST_MUL,
    ST_DONE
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic                 load;
    logic                 sum_en;
    logic                 div_step;
    logic [DIV_IDX_W-1:0] div_idx;
    logic                 diff_en;
    logic                 mul_en;
    logic                 commit;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic lf_mode;
    logic vel_zero;
  } status_t;

endpackage

/* src/lfmc_ctrl.sv */
// Sequencer of the line-follow motor controller.
// Uses lfmc_pkg; drives lfmc_dp through cmd_t, reads status_t.
module lfmc_ctrl #(
  parameter int unsigned SENSOR_COUNT = lfmc_pkg::SENSOR_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  input  lfmc_pkg::status_t status_i,
  output lfmc_pkg::cmd_t    cmd_o
);

  localparam int unsigned QW = $clog2(lfmc_pkg::POS_STEP * SENSOR_COUNT + 1);

  lfmc_pkg::state_e state_q, state_d;
  logic [lfmc_pkg::DIV_IDX_W-1:0] cnt_q, cnt_d;
  logic m_valid_q, m_valid_d;
  logic out_free;

  assign out_free = !m_valid_q || m_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      lfmc_pkg::ST_IDLE: begin
        if (s_valid_i) state_d = lfmc_pkg::ST_SUM;
      end
      lfmc_pkg::ST_SUM: begin
        cnt_d = lfmc_pkg::DIV_IDX_W'(QW - 1);
        if (status_i.lf_mode && !status_i.vel_zero) state_d = lfmc_pkg::ST_DIV;
        else state_d = lfmc_pkg::ST_DONE;
      end
      lfmc_pkg::ST_DIV: begin
        if (cnt_q == '0) state_d = lfmc_pkg::ST_DIFF;
        else cnt_d = cnt_q - 1'b1;
      end
      lfmc_pkg::ST_DIFF: state_d = lfmc_pkg::ST_MUL;
      lfmc_pkg::ST_MUL:  state_d = lfmc_pkg::ST_DONE;
      lfmc_pkg::ST_DONE: begin
        if (out_free) state_d = lfmc_pkg::ST_IDLE;
      end
      default: state_d = lfmc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    m_valid_d = m_valid_q && !m_ready_i;
    case (state_q)
      lfmc_pkg::ST_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.load = s_valid_i;
      end
      lfmc_pkg::ST_SUM:  cmd_o.sum_en = 1'b1;
      lfmc_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_idx  = cnt_q;
      end
      lfmc_pkg::ST_DIFF: cmd_o.diff_en = 1'b1;
      lfmc_pkg::ST_MUL:  cmd_o.mul_en  = 1'b1;
      lfmc_pkg::ST_DONE: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          m_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign m_valid_o = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lfmc_pkg::ST_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  // a result is only written into a free or draining output register
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!m_valid_q || m_ready_i))
    else $error("commit overwrote a pending result");

  // an accepted beat always starts the sensor scan
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o) |=> state_q == lfmc_pkg::ST_SUM)
    else $error("accepted beat did not start the scan");

  // every commit raises the output valid
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> m_valid_q)
    else $error("commit did not present a result");

  // the divider ends by stepping into the difference stage
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lfmc_pkg::ST_DIV && cnt_q == '0) |=> state_q == lfmc_pkg::ST_DIFF)
    else $error("divider overran");

endmodule

/* src/lfmc_dp.sv */
// Datapath of the line-follow motor controller: config registers, sensor
// scan, shift-subtract divider, gain multiply and saturation. Uses lfmc_pkg.
module lfmc_dp #(
  parameter int unsigned SENSOR_COUNT = lfmc_pkg::SENSOR_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lfmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lfmc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            command_i,
  input  logic signed [7:0]               velocity_i,
  input  logic [SENSOR_COUNT-1:0]         sensor_bits_i,
  input  lfmc_pkg::cmd_t                  cmd_i,
  output lfmc_pkg::status_t               status_o,
  output logic signed [7:0]               motor_one_power_o,
  output logic signed [7:0]               motor_two_power_o
);

  localparam int unsigned MAXPOS = lfmc_pkg::POS_STEP * SENSOR_COUNT;
  localparam int unsigned QW     = $clog2(MAXPOS + 1);
  localparam int unsigned POS_W  = (QW > 7) ? QW : 7;
  localparam int unsigned SUM_W  = $clog2(MAXPOS * (SENSOR_COUNT + 1) / 2 + 1);
  localparam int unsigned LIT_W  = $clog2(SENSOR_COUNT + 1);
  localparam int unsigned CMP_W  = SUM_W + QW;
  localparam int unsigned PROD_W = POS_W + 8;
  localparam int unsigned ARI_W  = PROD_W + 2;

  // configuration
  logic       lf_en_q;
  logic [6:0] target_q;
  logic [7:0] gain_q;
  logic [2:0] shift_q;
  logic [6:0] cutoff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lf_en_q  <= 1'b0;
      target_q <= lfmc_pkg::TARGET_RST;
      gain_q   <= lfmc_pkg::GAIN_RST;
      shift_q  <= lfmc_pkg::SHIFT_RST;
      cutoff_q <= lfmc_pkg::CUTOFF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lfmc_pkg::REG_LINE_FOLLOW_ENABLE: lf_en_q  <= cfg_wdata_i[0];
        lfmc_pkg::REG_TARGET_POSITION:    target_q <= cfg_wdata_i[6:0];
        lfmc_pkg::REG_GAIN_NUM:           gain_q   <= cfg_wdata_i;
        lfmc_pkg::REG_GAIN_SHIFT:         shift_q  <= cfg_wdata_i[2:0];
        lfmc_pkg::REG_POWER_CUTOFF:       cutoff_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // captured beat
  logic                    side_q;
  logic signed [7:0]       vel_q;
  logic [SENSOR_COUNT-1:0] bits_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      side_q <= command_i;
      vel_q  <= velocity_i;
      bits_q <= sensor_bits_i;
    end
  end

  assign status_o.lf_mode  = lf_en_q;
  assign status_o.vel_zero = (vel_q == '0);

  // sensor scan: weighted sum and lit count, sensor 0 is the MSB
  logic [SUM_W-1:0] sum_c;
  logic [LIT_W-1:0] lit_c;

  always_comb begin
    sum_c = '0;
    lit_c = '0;
    for (int unsigned i = 0; i < SENSOR_COUNT; i++) begin
      if (bits_q[SENSOR_COUNT-1-i]) begin
        sum_c = sum_c + SUM_W'(lfmc_pkg::POS_STEP * (i + 1));
        lit_c = lit_c + LIT_W'(1);
      end
    end
  end

  // divider: one quotient bit per step, MSB first
  logic [SUM_W-1:0] rem_q;
  logic [QW-1:0]    quo_q;
  logic [LIT_W-1:0] lit_q;
  logic [CMP_W-1:0] trial;
  logic             fits;

  assign trial = CMP_W'(lit_q) << cmd_i.div_idx;
  assign fits  = CMP_W'(rem_q) >= trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      rem_q <= sum_c;
      lit_q <= lit_c;
      quo_q <= '0;
    end else if (cmd_i.div_step && fits) begin
      rem_q <= SUM_W'(CMP_W'(rem_q) - trial);
      quo_q[cmd_i.div_idx] <= 1'b1;
    end
  end

  // position select
  lfmc_pkg::dir_e   dir_q;
  logic [POS_W-1:0] pos_c;
  logic             partial_lit;

  assign partial_lit = (lit_q != '0) && (lit_q != LIT_W'(SENSOR_COUNT));

  always_comb begin
    if (lit_q == '0) begin
      case (dir_q)
        lfmc_pkg::DIR_RIGHT: pos_c = POS_W'(lfmc_pkg::POS_RIGHT);
        lfmc_pkg::DIR_LEFT:  pos_c = POS_W'(lfmc_pkg::POS_LEFT);
        default:             pos_c = POS_W'(lfmc_pkg::POS_CENTER);
      endcase
    end else if (!partial_lit) begin
      pos_c = POS_W'(lfmc_pkg::POS_RIGHT);
    end else begin
      pos_c = POS_W'(quo_q);
    end
  end

  // difference stage
  logic signed [POS_W:0] diff_c;
  logic [POS_W-1:0]      mag_q;
  logic                  neg_q;
  logic                  dir_upd_q;
  lfmc_pkg::dir_e        dir_new_q;

  assign diff_c = $signed({1'b0, POS_W'(target_q)}) - $signed({1'b0, pos_c});

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_en) begin
      neg_q     <= diff_c[POS_W];
      mag_q     <= diff_c[POS_W] ? POS_W'(-diff_c) : POS_W'(diff_c);
      dir_upd_q <= partial_lit;
      if (pos_c > POS_W'(target_q))      dir_new_q <= lfmc_pkg::DIR_RIGHT;
      else if (pos_c < POS_W'(target_q)) dir_new_q <= lfmc_pkg::DIR_LEFT;
      else                               dir_new_q <= lfmc_pkg::DIR_STRAIGHT;
    end
  end

  // gain multiply
  logic [PROD_W-1:0] corr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) corr_q <= (PROD_W'(mag_q) * PROD_W'(gain_q)) >> shift_q;
  end

  // steering and saturation
  logic signed [ARI_W-1:0] vel_x, corr_x, p1_x, p2_x;
  logic signed [7:0]       p1_c, p2_c;

  function automatic logic signed [7:0] sat_power(input logic signed [ARI_W-1:0] v,
                                                  input logic [6:0] hi);
    logic signed [7:0] r;
    if (v > $signed(ARI_W'(hi)))          r = $signed({1'b0, hi});
    else if (v < -$signed(ARI_W'(128)))   r = -8'sd128;
    else                                  r = v[7:0];
    return r;
  endfunction

  assign vel_x  = ARI_W'(vel_q);
  assign corr_x = neg_q ? -$signed({2'b00, corr_q}) : $signed({2'b00, corr_q});
  assign p1_x   = vel_x - corr_x;
  assign p2_x   = vel_x + corr_x;

  // held powers and last direction
  logic signed [7:0] held1_q, held2_q;

  always_comb begin
    if (lf_en_q) begin
      if (vel_q == '0) begin
        p1_c = '0;
        p2_c = '0;
      end else begin
        p1_c = sat_power(p1_x, cutoff_q);
        p2_c = sat_power(p2_x, cutoff_q);
      end
    end else begin
      p1_c = side_q ? held1_q : vel_q;
      p2_c = side_q ? vel_q : held2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= lfmc_pkg::DIR_STRAIGHT;
      held1_q <= '0;
      held2_q <= '0;
    end else if (cmd_i.commit) begin
      if (lf_en_q) begin
        if (vel_q != '0 && dir_upd_q) dir_q <= dir_new_q;
      end else begin
        held1_q <= p1_c;
        held2_q <= p2_c;
      end
    end
  end

  // output register
  logic signed [7:0] out1_q, out2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out1_q <= p1_c;
      out2_q <= p2_c;
    end
  end

  assign motor_one_power_o = out1_q;
  assign motor_two_power_o = out2_q;

endmodule

/* src/line_follow_motor_controller_top.sv */
// Line-follow motor controller, top level.
// Uses lfmc_pkg, lfmc_ctrl and lfmc_dp.
//
// Usage:
//  - Slave stream (s_axis_*): one beat per velocity command. tuser is the
//    motor select (0 motor one, 1 motor two); tdata holds velocity and the
//    line sensor byte (sensor 0 in the MSB).
//  - Master stream (m_axis_*): one beat per input beat with both motor powers.
//  - Config port: cfg_we_i writes register cfg_idx_i with cfg_wdata_i
//    (0 line_follow_enable, 1 target_position, 2 gain_num, 3 gain_shift,
//    4 power_cutoff); other indexes are ignored. Write only while idle.
// Sequence:
//  - Line-follow beat with nonzero velocity: accept, scan, QW divide steps
//    (7 at 8 sensors), difference, multiply, commit, then m_axis_tvalid
//    rises from its register. Manual or zero-velocity beats: accept,
//    scan, commit.
//  - One item is in flight at a time.
//  - Input is taken again the cycle after commit, even while the result
//    sits in the output register; a stalled receiver holds the result and
//    only the next commit waits for it.
// Reset: registers go to their reset values, direction straight, held
//  powers zero, no result pending.
module line_follow_motor_controller_top #(
  parameter int unsigned SENSOR_COUNT = lfmc_pkg::SENSOR_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] velocity, [8+SENSOR_COUNT-1:8] sensor_bits, zero padded
  input  logic [((8+SENSOR_COUNT+7)/8)*8-1:0] s_axis_tdata,
  // [0] command
  input  logic                            s_axis_tuser,
  // master stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] motor_one_power, [15:8] motor_two_power
  output logic [15:0]                     m_axis_tdata,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [lfmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lfmc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  lfmc_pkg::cmd_t    cmd;
  lfmc_pkg::status_t status;
  logic signed [7:0] p1, p2;

  lfmc_ctrl #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  lfmc_dp #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .command_i         (s_axis_tuser),
    .velocity_i        ($signed(s_axis_tdata[7:0])),
    .sensor_bits_i     (s_axis_tdata[8+SENSOR_COUNT-1:8]),
    .cmd_i             (cmd),
    .status_o          (status),
    .motor_one_power_o (p1),
    .motor_two_power_o (p2)
  );

  assign m_axis_tdata = {p2, p1};

endmodule
